// ===== hw/rtl/pose_error_to_euler_assert.svh =====
// assertion macros for the pose error block
`ifndef POSE_ERROR_TO_EULER_ASSERT_SVH
`define POSE_ERROR_TO_EULER_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define PEE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pose error assertion failed");

// next-cycle implication checked outside reset
`define PEE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pose error assertion failed");

`endif

// ===== hw/rtl/pee_pkg.sv =====
package pee_pkg;

  localparam int unsigned CordicStages = 16;
  localparam int unsigned AngW = 34;
  localparam int unsigned VecW = 44;
  localparam int unsigned NumRegs = 7;
  localparam logic [34:0] Deg180 = 35'd11796480;
  localparam logic [14:0] AngleMax = 15'd23040;
  localparam logic [13:0] PitchMax = 14'd11520;

  typedef enum logic [2:0] {
    RegPosX  = 3'd0,
    RegPosY  = 3'd1,
    RegPosZ  = 3'd2,
    RegQuatX = 3'd3,
    RegQuatY = 3'd4,
    RegQuatZ = 3'd5,
    RegQuatW = 3'd6
  } reg_idx_e;

  function automatic logic signed [AngW-1:0] atan_lut(input int unsigned i);
    logic signed [AngW-1:0] v;
    unique case (i)
      0: v = 34'sd2949120;  1: v = 34'sd1740967;  2: v = 34'sd919879;
      3: v = 34'sd466945;   4: v = 34'sd234379;   5: v = 34'sd117304;
      6: v = 34'sd58666;    7: v = 34'sd29335;    8: v = 34'sd14668;
      9: v = 34'sd7334;     10: v = 34'sd3667;    11: v = 34'sd1833;
      12: v = 34'sd917;     13: v = 34'sd458;     14: v = 34'sd229;
      15: v = 34'sd115;     16: v = 34'sd57;      17: v = 34'sd29;
      18: v = 34'sd14;      19: v = 34'sd7;       20: v = 34'sd4;
      21: v = 34'sd2;       22: v = 34'sd1;       default: v = '0;
    endcase
    return v;
  endfunction

  typedef struct packed {
    logic signed [VecW-1:0] x;
    logic signed [VecW-1:0] y;
    logic signed [AngW-1:0] ang;
    logic                   done;
    logic                   neg;
  } cordic_t;

endpackage

// ===== hw/rtl/pee_rotmat.sv =====
// quaternion to rotation matrix, two stages: products then combine and floor to q.20
module pee_rotmat import pee_pkg::*; (
  input  logic               clk_i,
  input  logic signed [15:0] qx_i,
  input  logic signed [15:0] qy_i,
  input  logic signed [15:0] qz_i,
  input  logic signed [15:0] qw_i,
  output logic signed [25:0] r_o [9]
);
  logic signed [31:0] p_q [9];
  logic signed [31:0] p_d [9];
  logic signed [33:0] e [9];
  localparam logic signed [33:0] One = 34'sd268435456;

  always_comb begin
    p_d[0] = qx_i * qx_i; p_d[1] = qy_i * qy_i; p_d[2] = qz_i * qz_i;
    p_d[3] = qx_i * qy_i; p_d[4] = qx_i * qz_i; p_d[5] = qy_i * qz_i;
    p_d[6] = qx_i * qw_i; p_d[7] = qy_i * qw_i; p_d[8] = qz_i * qw_i;
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  always_comb begin
    e[0] = One - (34'(p_q[1]) + 34'(p_q[2])) * 2;
    e[1] = (34'(p_q[3]) - 34'(p_q[8])) * 2;
    e[2] = (34'(p_q[4]) + 34'(p_q[7])) * 2;
    e[3] = (34'(p_q[3]) + 34'(p_q[8])) * 2;
    e[4] = One - (34'(p_q[0]) + 34'(p_q[2])) * 2;
    e[5] = (34'(p_q[5]) - 34'(p_q[6])) * 2;
    e[6] = (34'(p_q[4]) - 34'(p_q[7])) * 2;
    e[7] = (34'(p_q[5]) + 34'(p_q[6])) * 2;
    e[8] = One - (34'(p_q[0]) + 34'(p_q[1])) * 2;
  end

  // non-unit quaternions push entries up to 2^24
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 9; i++) begin
      r_o[i] <= 26'(e[i] >>> 8);
    end
  end
endmodule

// ===== hw/rtl/pee_cordic.sv =====
// vectoring cordic atan2: a quadrant pre-rotation stage, then one micro-rotation per register stage
module pee_cordic import pee_pkg::*; (
  input  logic                    clk_i,
  input  logic signed [VecW-1:0]  y_i,
  input  logic signed [VecW-1:0]  x_i,
  output logic signed [AngW:0]    ang_o
);
  cordic_t st_q [CordicStages+1];
  cordic_t st_d [CordicStages+1];

  always_comb begin
    st_d[0].done = (y_i == '0);
    st_d[0].neg  = x_i[VecW-1];
    st_d[0].x    = x_i[VecW-1] ? -x_i : x_i;
    st_d[0].y    = x_i[VecW-1] ? -y_i : y_i;
    if (y_i == '0) st_d[0].ang = x_i[VecW-1] ? AngW'(Deg180) : '0;
    else if (x_i[VecW-1]) st_d[0].ang = y_i[VecW-1] ? -AngW'(Deg180) : AngW'(Deg180);
    else st_d[0].ang = '0;
    for (int i = 1; i <= CordicStages; i++) begin
      st_d[i] = st_q[i-1];
      if (!st_q[i-1].done) begin
        if (st_q[i-1].y > 0) begin
          st_d[i].x   = st_q[i-1].x + (st_q[i-1].y >>> (i-1));
          st_d[i].y   = st_q[i-1].y - (st_q[i-1].x >>> (i-1));
          st_d[i].ang = st_q[i-1].ang + atan_lut(i-1);
        end else begin
          st_d[i].x   = st_q[i-1].x - (st_q[i-1].y >>> (i-1));
          st_d[i].y   = st_q[i-1].y + (st_q[i-1].x >>> (i-1));
          st_d[i].ang = st_q[i-1].ang - atan_lut(i-1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  assign ang_o = (AngW+1)'(st_q[CordicStages].ang);
endmodule

// ===== hw/rtl/pee_isqrt.sv =====
// pipelined restoring square root, one result bit per stage
module pee_isqrt import pee_pkg::*; (
  input  logic        clk_i,
  input  logic [60:0] n_i,
  output logic [30:0] r_o
);
  logic [60:0] n_q [31];
  logic [60:0] n_d [31];
  logic [61:0] r_q [31];
  logic [61:0] r_d [31];
  logic [60:0] n_s [31];
  logic [61:0] r_s [31];

  // stage inputs: first stage straight from the port
  always_comb begin
    n_s[0] = n_i;
    r_s[0] = '0;
    for (int i = 1; i < 31; i++) begin
      n_s[i] = n_q[i-1];
      r_s[i] = r_q[i-1];
    end
  end

  always_comb begin
    logic [61:0] bitv;
    for (int i = 0; i < 31; i++) begin
      bitv = 62'd1 << (2 * (30 - i));
      if ({1'b0, n_s[i]} >= r_s[i] + bitv) begin
        n_d[i] = 61'({1'b0, n_s[i]} - (r_s[i] + bitv));
        r_d[i] = (r_s[i] >> 1) + bitv;
      end else begin
        n_d[i] = n_s[i];
        r_d[i] = r_s[i] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d;
    r_q <= r_d;
  end

  assign r_o = 31'(r_q[30]);
endmodule

// ===== hw/rtl/pose_error_to_euler.sv =====
// channel  | direction | handshake             | payload
// cmd      | in        | start / busy          | cur_pos_*_i, cur_quat_*_i
// result   | out       | done strobe           | err_pos_*_o, err_*_o
// config   | in        | cfg_valid_i/ready_o   | cfg_idx_i, cfg_data_i
// one item per cycle; pipeline stages: 2 matrix, 3 product, 1 clamp,
// 31 square root, 1 + CordicStages cordic and 1 round
// reset clears valid bits and config registers, but sets quat w to 1.0 (16384); pipeline data needs none
// busy is always low: nothing downstream can stall the pipeline
`include "pose_error_to_euler_assert.svh"
module pose_error_to_euler import pee_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  output logic               done,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic signed [31:0] cur_pos_x_i,
  input  logic signed [31:0] cur_pos_y_i,
  input  logic signed [31:0] cur_pos_z_i,
  input  logic signed [15:0] cur_quat_x_i,
  input  logic signed [15:0] cur_quat_y_i,
  input  logic signed [15:0] cur_quat_z_i,
  input  logic signed [15:0] cur_quat_w_i,
  output logic [31:0]        err_pos_x_o,
  output logic [31:0]        err_pos_y_o,
  output logic [31:0]        err_pos_z_o,
  output logic [14:0]        err_roll_o,
  output logic [13:0]        err_pitch_o,
  output logic [14:0]        err_yaw_o
);
  localparam int unsigned Lat = 2 + 3 + 1 + 31 + 1 + CordicStages + 1;
  localparam logic signed [VecW-1:0] OneQ30 = VecW'(1 << 30);

  logic signed [31:0] ref_pos_q [3];
  logic signed [15:0] ref_quat_q [4];

  // config registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_pos_q[0] <= '0; ref_pos_q[1] <= '0; ref_pos_q[2] <= '0;
      ref_quat_q[0] <= '0; ref_quat_q[1] <= '0; ref_quat_q[2] <= '0;
      ref_quat_q[3] <= 16'sd16384;
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        RegPosX:  ref_pos_q[0] <= cfg_data_i;
        RegPosY:  ref_pos_q[1] <= cfg_data_i;
        RegPosZ:  ref_pos_q[2] <= cfg_data_i;
        RegQuatX: ref_quat_q[0] <= cfg_data_i[15:0];
        RegQuatY: ref_quat_q[1] <= cfg_data_i[15:0];
        RegQuatZ: ref_quat_q[2] <= cfg_data_i[15:0];
        RegQuatW: ref_quat_q[3] <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // valid shift line
  logic [Lat-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else vld_q <= {vld_q[Lat-2:0], start};
  end
  assign done = vld_q[Lat-1];

  // position error, computed at entry then delayed
  logic [31:0] pe_d [3];
  logic [31:0] pe_q [Lat][3];
  always_comb begin
    logic signed [32:0] dd;
    dd = 33'(cur_pos_x_i) - 33'(ref_pos_q[0]);
    pe_d[0] = 32'(dd[32] ? -dd : dd);
    dd = 33'(cur_pos_y_i) - 33'(ref_pos_q[1]);
    pe_d[1] = 32'(dd[32] ? -dd : dd);
    dd = 33'(cur_pos_z_i) - 33'(ref_pos_q[2]);
    pe_d[2] = 32'(dd[32] ? -dd : dd);
  end
  always_ff @(posedge clk_i) begin
    pe_q[0] <= pe_d;
    for (int i = 1; i < Lat; i++) pe_q[i] <= pe_q[i-1];
  end
  assign err_pos_x_o = pe_q[Lat-1][0];
  assign err_pos_y_o = pe_q[Lat-1][1];
  assign err_pos_z_o = pe_q[Lat-1][2];

  // rotation matrices
  logic signed [25:0] ra [9];
  logic signed [25:0] rb [9];
  pee_rotmat u_ra (.clk_i, .qx_i(ref_quat_q[0]), .qy_i(ref_quat_q[1]),
                   .qz_i(ref_quat_q[2]), .qw_i(ref_quat_q[3]), .r_o(ra));
  pee_rotmat u_rb (.clk_i, .qx_i(cur_quat_x_i), .qy_i(cur_quat_y_i),
                   .qz_i(cur_quat_z_i), .qw_i(cur_quat_w_i), .r_o(rb));

  // m = a^T b: products, then sum, then floor to q.30
  logic signed [51:0] pr_q [15];
  logic signed [51:0] sm_q [5];
  logic signed [VecW-1:0] m_q [5];
  // entries used: m00, m10, m20, m21, m22
  localparam int MI [5] = '{0, 1, 2, 2, 2};
  localparam int MJ [5] = '{0, 0, 0, 1, 2};
  always_ff @(posedge clk_i) begin
    for (int e = 0; e < 5; e++) begin
      for (int k = 0; k < 3; k++) begin
        pr_q[e*3+k] <= 52'(ra[k*3+MI[e]] * rb[k*3+MJ[e]]);
      end
      sm_q[e] <= pr_q[e*3] + pr_q[e*3+1] + pr_q[e*3+2];
      m_q[e] <= VecW'(sm_q[e] >>> 10);
    end
  end

  // pitch: clamp and square
  logic signed [31:0] s_q;
  logic signed [VecW-1:0] s_d;
  logic signed [31:0] s_c;
  logic signed [63:0] s_sq;
  logic signed [VecW-1:0] roll_y_q [32], roll_x_q [32], yaw_y_q [32], yaw_x_q [32];
  logic signed [31:0] s_dl [31];
  logic [60:0] sq_q;
  always_comb begin
    s_d = m_q[2];
    if (s_d > OneQ30) s_d = OneQ30;
    if (s_d < -OneQ30) s_d = -OneQ30;
    s_c = 32'(s_d);
    s_sq = s_c * s_c;
  end
  always_ff @(posedge clk_i) begin
    s_q <= s_c;
    roll_y_q[0] <= m_q[3]; roll_x_q[0] <= m_q[4];
    yaw_y_q[0] <= m_q[1];  yaw_x_q[0] <= m_q[0];
    sq_q <= 61'(62'h1000000000000000 - 62'(s_sq));
    s_dl[0] <= s_q;
    for (int i = 1; i < 31; i++) s_dl[i] <= s_dl[i-1];
    for (int i = 1; i < 32; i++) begin
      roll_y_q[i] <= roll_y_q[i-1]; roll_x_q[i] <= roll_x_q[i-1];
      yaw_y_q[i] <= yaw_y_q[i-1];   yaw_x_q[i] <= yaw_x_q[i-1];
    end
  end

  logic [30:0] c_w;
  pee_isqrt u_sqrt (.clk_i, .n_i(sq_q), .r_o(c_w));

  logic signed [AngW:0] a_roll, a_pitch, a_yaw;
  pee_cordic u_roll  (.clk_i, .y_i(roll_y_q[31]), .x_i(roll_x_q[31]), .ang_o(a_roll));
  pee_cordic u_pitch (.clk_i, .y_i(VecW'(s_dl[30])), .x_i(VecW'({1'b0, c_w})),
                      .ang_o(a_pitch));
  pee_cordic u_yaw   (.clk_i, .y_i(yaw_y_q[31]), .x_i(yaw_x_q[31]), .ang_o(a_yaw));

  // round magnitude half up and saturate
  function automatic logic [14:0] units(input logic signed [AngW:0] a,
                                        input logic [14:0] lim);
    logic [AngW:0] m;
    logic [AngW:0] u;
    m = a[AngW] ? (AngW+1)'(-a) : a;
    u = (m + 35'd256) >> 9;
    return (u > 35'(lim)) ? lim : 15'(u);
  endfunction

  always_ff @(posedge clk_i) begin
    err_roll_o  <= units(a_roll, AngleMax);
    err_pitch_o <= 14'(units(a_pitch, 15'(PitchMax)));
    err_yaw_o   <= units(a_yaw, AngleMax);
  end

  `PEE_ASSERT_IMP(a_busy_low, clk_i, rst_ni, 1'b1, !busy)
  `PEE_ASSERT_NEXT(a_start_tracks, clk_i, rst_ni, start, vld_q[0])
  `PEE_ASSERT_IMP(a_pitch_range, clk_i, rst_ni, done, err_pitch_o <= PitchMax)
endmodule
